/* src/lxm_pkg.sv */
// Shared constants, types and arithmetic helpers for the LXM random generator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lxm_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned WORD_W  = 32;

    localparam logic [STATE_W-1:0] LCG_MUL = 64'hD1342543DE82EF95;
    localparam logic [STATE_W-1:0] LCG_INC = 64'h0000000000000001;
    localparam logic [STATE_W-1:0] MIX_MUL = 64'hDABA0B6EB09322E3;
    localparam logic [STATE_W-1:0] GOLDEN  = 64'h9E3779B97F4A7C15;

    localparam int unsigned MIX_SHIFT = 32;
    localparam int unsigned ROT_A     = 24;
    localparam int unsigned SHL_B     = 16;
    localparam int unsigned ROT_C     = 37;

    // Depth of the queue between the front and back parts (power of two, >= 2)
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef logic [STATE_W-1:0] t_state_word;

    // Partial products of a 64x64 multiply, modulo 2^64
    typedef struct packed {
        logic [STATE_W-1:0] p0;   // low x low, full width
        logic [HALF_W-1:0]  p1;   // low x high, low half
        logic [HALF_W-1:0]  p2;   // high x low, low half
    } t_mul_parts;

    function automatic t_state_word rotl64(input t_state_word v, input int unsigned r);
        return (v << r) | (v >> (STATE_W - r));
    endfunction

    function automatic t_mul_parts mul_parts(input t_state_word a, input t_state_word b);
        t_mul_parts res;
        res.p0 = {32'h0, a[HALF_W-1:0]} * {32'h0, b[HALF_W-1:0]};
        res.p1 = a[HALF_W-1:0] * b[STATE_W-1:HALF_W];
        res.p2 = a[STATE_W-1:HALF_W] * b[HALF_W-1:0];
        return res;
    endfunction

    function automatic t_state_word mul_join(input t_mul_parts p);
        return p.p0 + {p.p1 + p.p2, 32'h0};
    endfunction

endpackage

`default_nettype wire

/* src/lxm_if.sv */
// Valid/ready channel interfaces: request, response and the internal word queue.
// Widths come from lxm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lxm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [lxm_pkg::STATE_W-1:0] seed_value;

    modport source (output valid, op, seed_value, input ready);
    modport sink   (input valid, op, seed_value, output ready);
endinterface

interface lxm_out_if;
    logic                       valid;
    logic                       ready;
    logic [lxm_pkg::WORD_W-1:0] random_word;

    modport source (output valid, random_word, input ready);
    modport sink   (input valid, random_word, output ready);
endinterface

interface lxm_word_if;
    logic                        valid;
    logic                        ready;
    logic [lxm_pkg::STATE_W-1:0] word;

    modport source (output valid, word, input ready);
    modport sink   (input valid, word, output ready);
endinterface

`default_nettype wire

/* src/lxm_fifo.sv */
// Small register queue carrying pre-mix sums from the front to the back part.
// Depends on lxm_pkg and lxm_word_if.
`timescale 1ns / 1ps
`default_nettype none

module lxm_fifo #(
    parameter int unsigned DEPTH = lxm_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lxm_word_if.sink    i_push,
    lxm_word_if.source  o_pop
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [lxm_pkg::STATE_W-1:0] r_mem [DEPTH];
    logic [AW:0]                 r_wr_ptr, n_wr_ptr;
    logic [AW:0]                 r_rd_ptr, n_rd_ptr;
    logic                        w_full;
    logic                        w_empty;
    logic                        w_push;
    logic                        w_pop;
    logic [AW:0]                 w_count;

    assign w_empty = (r_wr_ptr == r_rd_ptr);
    assign w_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign w_count = r_wr_ptr - r_rd_ptr;

    assign i_push.ready = !w_full;
    assign o_pop.valid  = !w_empty;
    assign o_pop.word   = r_mem[r_rd_ptr[AW-1:0]];

    assign w_push = i_push.valid && i_push.ready;
    assign w_pop  = o_pop.valid && o_pop.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_push.word;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= (AW+1)'(DEPTH))
        else $error("queue holds more entries than its depth");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_count == $past(w_count) + 1'b1))
        else $error("queue count did not advance on a lone push");
`endif

endmodule

`default_nettype wire

/* src/lxm_front.sv */
// Front part: accepts requests, holds the LCG and xoroshiro128 state and
// queues the LCG-plus-low-word sum of each draw. Depends on lxm_pkg and lxm_if.
`timescale 1ns / 1ps
`default_nettype none

module lxm_front (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lxm_in_if.sink      i_req,
    lxm_word_if.source  o_push
);

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_LCG  = 2'b10
    } t_front_state;

    t_front_state         r_state, n_state;
    lxm_pkg::t_state_word r_lcg, n_lcg;
    lxm_pkg::t_state_word r_xlo, n_xlo;
    lxm_pkg::t_state_word r_xhi, n_xhi;
    lxm_pkg::t_mul_parts  r_parts;
    lxm_pkg::t_state_word w_hi;
    logic                 w_accept;
    logic                 w_draw;

    assign i_req.ready  = (r_state == FS_IDLE) && o_push.ready;
    assign o_push.valid = i_req.valid && (r_state == FS_IDLE) &&
                          (i_req.op == lxm_pkg::OP_DRAW);
    assign o_push.word  = r_lcg + r_xlo;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_draw   = w_accept && (i_req.op == lxm_pkg::OP_DRAW);
    assign w_hi     = r_xhi ^ r_xlo;

    always_comb begin
        n_state = r_state;
        n_lcg   = r_lcg;
        n_xlo   = r_xlo;
        n_xhi   = r_xhi;
        case (r_state)
            FS_IDLE: begin
                if (w_accept && (i_req.op == lxm_pkg::OP_SEED)) begin
                    n_lcg = i_req.seed_value;
                    n_xlo = lxm_pkg::GOLDEN + i_req.seed_value;
                    n_xhi = lxm_pkg::GOLDEN - i_req.seed_value;
                end else if (w_draw) begin
                    // advance xoroshiro now; LCG finishes next cycle
                    n_xlo   = lxm_pkg::rotl64(r_xlo, lxm_pkg::ROT_A) ^ w_hi ^
                              (w_hi << lxm_pkg::SHL_B);
                    n_xhi   = lxm_pkg::rotl64(w_hi, lxm_pkg::ROT_C);
                    n_state = FS_LCG;
                end
            end
            FS_LCG: begin
                n_lcg   = lxm_pkg::mul_join(r_parts) + lxm_pkg::LCG_INC;
                n_state = FS_IDLE;
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_lcg   <= '0;
            r_xlo   <= lxm_pkg::GOLDEN;
            r_xhi   <= lxm_pkg::GOLDEN;
        end else begin
            r_state <= n_state;
            r_lcg   <= n_lcg;
            r_xlo   <= n_xlo;
            r_xhi   <= n_xhi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_parts <= lxm_pkg::mul_parts(r_lcg, lxm_pkg::LCG_MUL);
    end

`ifndef ASSERT_OFF
    a_push_is_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.ready) |->
            (i_req.valid && i_req.ready && i_req.op == lxm_pkg::OP_DRAW))
        else $error("queue push without an accepted draw");

    a_draw_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw |=> (r_state == FS_LCG) && !i_req.ready)
        else $error("request taken while the LCG step is pending");
`endif

endmodule

`default_nettype wire

/* src/lxm_back.sv */
// Back part: runs the two-round multiply-xorshift mix on one queued sum at a
// time and holds the result in an output register. Depends on lxm_pkg, lxm_if.
`timescale 1ns / 1ps
`default_nettype none

module lxm_back (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lxm_word_if.sink    i_pop,
    lxm_out_if.source   o_rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_SUM  = 3'b100
    } t_back_state;

    t_back_state                 r_state, n_state;
    logic                        r_round, n_round;
    lxm_pkg::t_state_word        r_v, n_v;
    lxm_pkg::t_mul_parts         r_parts;
    logic                        r_out_valid, n_out_valid;
    logic [lxm_pkg::WORD_W-1:0]  r_out_word, n_out_word;
    lxm_pkg::t_state_word        w_prod;
    lxm_pkg::t_state_word        w_x;
    logic                        w_slot_free;
    logic                        w_pop;

    assign i_pop.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.random_word = r_out_word;

    assign w_pop       = i_pop.valid && i_pop.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_prod      = lxm_pkg::mul_join(r_parts);
    assign w_x         = w_prod ^ (w_prod >> lxm_pkg::MIX_SHIFT);

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_v         = r_v;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    n_v     = i_pop.word ^ (i_pop.word >> lxm_pkg::MIX_SHIFT);
                    n_round = 1'b0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (!r_round) begin
                    n_v     = w_x;
                    n_round = 1'b1;
                    n_state = ST_MUL;
                end else if (w_slot_free) begin
                    // hold here until the output register can take the word
                    n_out_valid = 1'b1;
                    n_out_word  = w_x[lxm_pkg::WORD_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_out_word <= n_out_word;
        if (r_state == ST_MUL) begin
            r_parts <= lxm_pkg::mul_parts(r_v, lxm_pkg::MIX_MUL);
        end
    end

`ifndef ASSERT_OFF
    a_pop_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == ST_MUL) && !r_round)
        else $error("mix did not start in its first round after a pop");
`endif

endmodule

`default_nettype wire

/* src/lxm_random_generator.sv */
// Top level of the LXM random generator: front part, word queue, mix back part.
// Depends on lxm_pkg, lxm_if, lxm_fifo, lxm_front and lxm_back.
//
//   port    | dir | payload                      | transaction
//   --------+-----+------------------------------+----------------------------------
//   i_req   | in  | op (1), seed_value (64)      | draw one word, or seed the state
//   o_rsp   | out | random_word (32)             | one mixed word per draw
//
// A seed is taken in FS_IDLE; a draw also passes through FS_LCG (the LCG
// multiply is done as registered partial products, then summed). The back mixes
// one word at a time (pop in ST_IDLE, then two ST_MUL/ST_SUM multiply/sum rounds
// on one shared multiplier) and pops no new word until it is back in ST_IDLE.
// Reset loads the state of a seed of zero.
// A stalled o_rsp fills the output register, then the queue, then blocks i_req.
`timescale 1ns / 1ps
`default_nettype none

module lxm_random_generator #(
    parameter int unsigned QUEUE_DEPTH = lxm_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lxm_in_if.sink      i_req,
    lxm_out_if.source   o_rsp
);

    lxm_word_if w_push ();
    lxm_word_if w_pop ();

    lxm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_push  (w_push)
    );

    lxm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_pop   (w_pop)
    );

    lxm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for lxm_random_generator: draws and seeds on i_req, words on o_rsp.
// Predicts each word with its own LCG/xoroshiro128 state; depends on lxm_pkg and lxm_if.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 700;
    localparam int RANDOM_REQS = 1800;
    localparam int DRAIN_WAIT  = 20;

    // Tracks the generator state and the words still owed on o_rsp
    class lxm_draw_scoreboard;
        logic [63:0] lcg_state;
        logic [63:0] xs_low;
        logic [63:0] xs_high;
        logic [31:0] owed_words[$];
        int          errors;

        function new();
            reseed(64'h0);
            errors = 0;
        endfunction

        function void reseed(logic [63:0] seed);
            lcg_state = seed;
            xs_low    = lxm_pkg::GOLDEN + seed;
            xs_high   = lxm_pkg::GOLDEN - seed;
        endfunction

        function logic [63:0] rot_left(logic [63:0] v, int unsigned r);
            return (v << r) | (v >> (64 - r));
        endfunction

        function logic [63:0] lea_round(logic [63:0] v);
            return (v ^ (v >> lxm_pkg::MIX_SHIFT)) * lxm_pkg::MIX_MUL;
        endfunction

        // Advance the model by one accepted request
        function void note_request(logic op, logic [63:0] seed);
            logic [63:0] mixed;
            logic [63:0] lo;
            logic [63:0] hi;
            if (op == lxm_pkg::OP_SEED) begin
                reseed(seed);
                return;
            end
            mixed = lea_round(lea_round(lcg_state + xs_low));
            mixed = mixed ^ (mixed >> lxm_pkg::MIX_SHIFT);
            owed_words.push_back(mixed[31:0]);
            lcg_state = lcg_state * lxm_pkg::LCG_MUL + lxm_pkg::LCG_INC;
            lo = xs_low;
            hi = xs_high ^ lo;
            xs_low  = rot_left(lo, lxm_pkg::ROT_A) ^ hi ^ (hi << lxm_pkg::SHL_B);
            xs_high = rot_left(hi, lxm_pkg::ROT_C);
        endfunction

        function void check_word(logic [31:0] word);
            logic [31:0] want;
            if (owed_words.size() == 0) begin
                $display("%0t: unexpected word, actual %08h", $time, word);
                errors++;
                return;
            end
            want = owed_words.pop_front();
            if (word !== want) begin
                $display("%0t: random_word mismatch, expected %08h, actual %08h",
                         $time, want, word);
                errors++;
            end
        endfunction

        function int pending();
            return owed_words.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   accepted_reqs = 0;

    lxm_draw_scoreboard board = new();

    lxm_in_if  req_if();
    lxm_out_if rsp_if();

    lxm_random_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            board.check_word(rsp_if.random_word);
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(logic op, logic [63:0] seed, int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.seed_value <= seed;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(op, seed);
        accepted_reqs++;
    endtask

    task automatic seed_req(logic [63:0] seed);
        send_req(lxm_pkg::OP_SEED, seed, pick_gap());
    endtask

    task automatic draw_req(logic [63:0] junk);
        send_req(lxm_pkg::OP_DRAW, junk, pick_gap());
    endtask

    // Receiver side: random ready pattern, one long hold-off partway through
    initial begin
        bit held;
        int r;
        held = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && accepted_reqs >= HOLD_AFTER) begin
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    rsp_if.ready <= 1'b1;
                    repeat (100) @(posedge i_clk);
                end else if (r < 70) begin
                    rsp_if.ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end else begin
                    rsp_if.ready <= 1'b0;
                    repeat (pick_gap() + 1) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        logic        op;
        logic [63:0] seed;
        int          burst_left;
        int          gap;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.op         <= lxm_pkg::OP_DRAW;
        req_if.seed_value <= 64'h0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset state, extreme seeds, ignored seed_value, back-to-back seeds
        draw_req(64'h0);
        draw_req(64'h0);
        seed_req(64'h0);
        draw_req(64'h0);
        seed_req(64'hFFFF_FFFF_FFFF_FFFF);
        draw_req(64'hFFFF_FFFF_FFFF_FFFF);
        draw_req(64'h0);
        seed_req(64'h1);
        draw_req(64'h0);
        seed_req(64'h8000_0000_0000_0000);
        draw_req(64'h0);
        seed_req(lxm_pkg::GOLDEN);
        draw_req(64'h0);
        seed_req(64'h0 - lxm_pkg::GOLDEN);
        draw_req(64'h0);
        seed_req(64'hA5A5_A5A5_A5A5_A5A5);
        seed_req(64'h5A5A_5A5A_5A5A_5A5A);
        draw_req(64'h5555_5555_5555_5555);
        draw_req(64'hAAAA_AAAA_AAAA_AAAA);
        seed_req(64'h0000_0000_FFFF_FFFF);
        draw_req(64'h0);
        send_req(lxm_pkg::OP_SEED, 64'hFFFF_FFFF_0000_0000, 0);
        send_req(lxm_pkg::OP_DRAW, 64'h0, 0);
        send_req(lxm_pkg::OP_DRAW, 64'h0, 0);

        burst_left = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            // Every so often, run a stretch with no gaps at all
            if (burst_left == 0 && $urandom_range(0, 199) == 0) burst_left = 60;
            op   = ($urandom_range(0, 99) < 12) ? lxm_pkg::OP_SEED : lxm_pkg::OP_DRAW;
            seed = {$urandom, $urandom};
            if ($urandom_range(0, 19) == 0) seed = $urandom_range(0, 1) ? '1 : '0;
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = pick_gap();
            end
            send_req(op, seed, gap);
        end
        req_if.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* lxm_random_generator.f */
src/lxm_pkg.sv
src/lxm_if.sv
src/lxm_fifo.sv
src/lxm_front.sv
src/lxm_back.sv
src/lxm_random_generator.sv
tb/sv/tb_top.sv
